// ===== sv/kbt_pkg.sv =====
// Shared types and constants for the keyed block transposition block.
package kbt_pkg;

  localparam int BYTE_W      = 8;
  localparam int KEY_LEN_W   = 5;
  localparam int KEY_LEN_MIN = 2;
  localparam int KEY_BYTES   = 16;
  localparam int KEY_HALF    = KEY_BYTES / 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 2'd3;

  typedef enum logic [1:0] {
    ST_BUILD,
    ST_IDLE,
    ST_EMIT
  } kbt_state_t;

  typedef struct packed {
    logic in_ready;
    logic build_step;
    logic emit_step;
  } kbt_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic rebuild;
    logic build_last;
    logic row_done;
    logic no_result;
    logic out_free;
    logic emit_last;
  } kbt_stat_t;

endpackage

// ===== sv/kbt_if.sv =====
// Channel interfaces: message input, result output and configuration writes.
interface kbt_msg_if import kbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface kbt_res_if import kbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              status;

  modport source (output valid, output out_byte, output out_last, output status, input ready);
  modport sink (input valid, input out_byte, input out_last, input status, output ready);
endinterface

interface kbt_cfg_if import kbt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== sv/kbt_ctrl.sv =====
// Sequencing state machine: order build, byte intake and row emission.
module kbt_ctrl import kbt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  kbt_stat_t stat,
  output kbt_cmd_t  cmd
);

  kbt_state_t state;
  kbt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BUILD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_BUILD: begin
        cmd.build_step = 1'b1;
        if (stat.build_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid && stat.row_done) begin
          state_next = stat.no_result ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_step = stat.out_free;
        if (stat.out_free && stat.emit_last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_BUILD;
      end
    endcase
    // key or width change: column order must be rebuilt
    if (stat.rebuild) state_next = ST_BUILD;
  end

endmodule

// ===== sv/kbt_dp.sv =====
// Datapath: config registers, column order tables, row store and result register.
module kbt_dp import kbt_pkg::*; #(
  parameter int KEY_MAX = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  kbt_cmd_t        cmd,
  output kbt_stat_t       stat,
  kbt_msg_if.sink         msg,
  kbt_res_if.source       res,
  kbt_cfg_if.sink         cfg
);

  localparam int IW = $clog2(KEY_MAX);
  localparam int CW = $clog2(KEY_MAX + 1);

  // configuration
  logic [KEY_LEN_W-1:0]  key_length;
  logic [CFG_DATA_W-1:0] key_low;
  logic [CFG_DATA_W-1:0] key_high;
  logic                  mode;
  logic                  cfg_we;
  logic                  rebuild;
  logic                  row_drop;
  logic [CW-1:0]         w;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;
  assign rebuild   = cfg_we && (cfg.reg_index == REG_KEY_LENGTH ||
                                cfg.reg_index == REG_KEY_LOW ||
                                cfg.reg_index == REG_KEY_HIGH);
  assign row_drop  = cfg_we && (cfg.reg_index == REG_KEY_LENGTH ||
                                cfg.reg_index == REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_W'(KEY_LEN_MIN);
      key_low    <= '0;
      key_high   <= '0;
      mode       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg.reg_index)
        REG_KEY_LENGTH: key_length <= cfg.wdata[KEY_LEN_W-1:0];
        REG_KEY_LOW:    key_low    <= cfg.wdata;
        REG_KEY_HIGH:   key_high   <= cfg.wdata;
        REG_MODE:       mode       <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_length < KEY_LEN_W'(KEY_LEN_MIN)) begin
      w = CW'(KEY_LEN_MIN);
    end else if (32'(key_length) > KEY_MAX) begin
      w = CW'(KEY_MAX);
    end else begin
      w = CW'(key_length);
    end
  end

  // key bytes; positions past the two key registers read as zero
  logic [BYTE_W-1:0] kb [KEY_MAX];

  for (genvar j = 0; j < KEY_MAX; j++) begin : g_kb
    if (j < KEY_HALF) begin : g_lo
      assign kb[j] = key_low[BYTE_W*j +: BYTE_W];
    end else if (j < KEY_BYTES) begin : g_hi
      assign kb[j] = key_high[BYTE_W*(j-KEY_HALF) +: BYTE_W];
    end else begin : g_zero
      assign kb[j] = '0;
    end
  end

  // order build: one key position per cycle, its stable rank by parallel compare
  logic [IW-1:0]      bi;
  logic [BYTE_W-1:0]  kv;
  logic [KEY_MAX-1:0] lt;
  logic [IW-1:0]      rank;
  logic               bi_in_row;
  logic [IW-1:0]      order [KEY_MAX];
  logic [IW-1:0]      inv   [KEY_MAX];

  assign kv = kb[bi];

  always_comb begin
    for (int j = 0; j < KEY_MAX; j++) begin
      lt[j] = (CW'(j) < w) && (kb[j] < kv || (kb[j] == kv && IW'(j) < bi));
    end
  end

  assign rank      = IW'($countones(lt));
  assign bi_in_row = CW'(bi) < w;

  always_ff @(posedge clk) begin
    if (rst || rebuild) begin
      bi <= '0;
    end else if (cmd.build_step) begin
      bi <= bi + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_step && !rebuild) begin
      if (bi_in_row) begin
        order[rank] <= bi;
        inv[bi]     <= rank;
      end else begin
        order[bi] <= bi;
        inv[bi]   <= bi;
      end
    end
  end

  // intake
  logic [BYTE_W-1:0] row_store [KEY_MAX];
  logic [CW-1:0]     fill;
  logic [CW-1:0]     fill_inc;
  logic [IW-1:0]     fill_idx;
  logic [CW-1:0]     hi;       // plaintext length up to the last non-pad byte
  logic [CW-1:0]     pos_plus;
  logic [CW-1:0]     hi_new;
  logic              take;
  logic              full;
  logic              row_done;
  logic              err_row;
  logic              no_result;
  logic [CW-1:0]     n_new;

  assign msg.ready = cmd.in_ready;
  assign take      = msg.valid && cmd.in_ready;
  assign fill_idx  = fill[IW-1:0];
  assign fill_inc  = fill + CW'(1);
  assign full      = fill_inc == w;
  assign pos_plus  = CW'(order[fill_idx]) + CW'(1);
  assign hi_new    = (msg.in_byte != PAD_BYTE && pos_plus > hi) ? pos_plus : hi;
  assign row_done  = full || msg.in_last;
  assign err_row   = mode && !full && msg.in_last;
  assign no_result = mode && full && msg.in_last && hi_new == '0;
  assign n_new     = err_row ? CW'(1) : ((mode && msg.in_last) ? hi_new : w);

  always_ff @(posedge clk) begin
    if (take) row_store[fill_idx] <= msg.in_byte;
  end

  // emission
  logic [CW-1:0]     c;
  logic [IW-1:0]     c_idx;
  logic [CW-1:0]     n;
  logic              e_last;
  logic              e_err;
  logic              emit_last;
  logic [IW-1:0]     enc_pos;
  logic [BYTE_W-1:0] enc_byte;
  logic [BYTE_W-1:0] dec_byte;
  logic [BYTE_W-1:0] res_byte;
  logic              out_valid;
  logic              out_free;

  assign c_idx     = c[IW-1:0];
  assign emit_last = (c + CW'(1)) == n;
  assign enc_pos   = order[c_idx];
  assign enc_byte  = (CW'(enc_pos) < fill) ? row_store[enc_pos] : PAD_BYTE;
  assign dec_byte  = row_store[inv[c_idx]];
  assign res_byte  = e_err ? '0 : (mode ? dec_byte : enc_byte);
  assign out_free  = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst || row_drop) begin
      fill <= '0;
      hi   <= '0;
    end else if (take) begin
      if (row_done && no_result) begin
        fill <= '0;
        hi   <= '0;
      end else begin
        fill <= fill_inc;
        hi   <= hi_new;
      end
    end else if (cmd.emit_step && emit_last) begin
      fill <= '0;
      hi   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || take) begin
      c <= '0;
    end else if (cmd.emit_step) begin
      c <= c + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take && row_done) begin
      n      <= n_new;
      e_last <= msg.in_last;
      e_err  <= err_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      res.out_byte <= res_byte;
      res.out_last <= e_err || (e_last && emit_last);
      res.status   <= e_err;
    end
  end

  assign res.valid = out_valid;

  always_comb begin
    stat            = '0;
    stat.in_valid   = msg.valid;
    stat.rebuild    = rebuild;
    stat.build_last = bi == IW'(KEY_MAX - 1);
    stat.row_done   = row_done;
    stat.no_result  = no_result;
    stat.out_free   = out_free;
    stat.emit_last  = emit_last;
  end

endmodule

// ===== sv/keyed_block_transposition.sv =====
// Top level of the keyed block transposition cipher.
//
// msg carries message bytes (in_byte, in_last marks the final byte); res
// carries result words (out_byte, out_last, status); cfg writes the four
// registers key_length, key_bytes_low, key_bytes_high, decrypt_mode at
// indexes 0..3. cfg is always ready.
// Bytes are gathered into a row as wide as the key, one byte per cycle
// while msg.ready is high. The word that completes a row (or carries
// in_last) starts the drain: msg.ready drops and the row leaves one word
// per cycle from the result register while res is ready, the first word
// loaded from the EMIT state. The single row store takes no new byte
// until the row has drained. Decrypt final rows drop trailing 0xFF bytes;
// an all-pad final row gives no word. A short final decrypt row gives one
// word with status set. After reset, and after any write to key_length or
// the key bytes, the column order is rebuilt one position per cycle over
// all KEY_MAX positions, with msg.ready low. Reset also empties the row
// and drops out_valid. When res stalls, the held word and drain pause.
module keyed_block_transposition import kbt_pkg::*; #(
  parameter int KEY_MAX = 16
) (
  input  logic       clk,
  input  logic       rst,
  kbt_msg_if.sink    msg,
  kbt_res_if.source  res,
  kbt_cfg_if.sink    cfg
);

  kbt_cmd_t  cmd;
  kbt_stat_t stat;

  kbt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  kbt_dp #(
    .KEY_MAX (KEY_MAX)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .msg  (msg),
    .res  (res),
    .cfg  (cfg)
  );

endmodule

// ===== sv/kbt_checker.sv =====
// Port-level checks for the keyed block transposition block, bound to the top.
module kbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       msg_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_byte,
  input logic       res_last,
  input logic       res_status
);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) &&
                                $stable(res_last) && $stable(res_status))
    else $error("result word changed while stalled");

  // a length error is a lone closing word with zero data
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status |-> res_last && res_byte == 8'h00)
    else $error("error word not closing or not zero");

  // input ready stays low out of reset, while the column order is rebuilt
  a_rst_build: assert property (@(posedge clk)
    rst |=> !msg_ready)
    else $error("input ready during order build after reset");

endmodule

bind keyed_block_transposition kbt_checker u_kbt_checker (
  .clk        (clk),
  .rst        (rst),
  .msg_ready  (msg.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_byte   (res.out_byte),
  .res_last   (res.out_last),
  .res_status (res.status)
);

// ===== test/tb_keyed_block_transposition.sv =====
// Self-checking testbench for the keyed block transposition block.
module tb_keyed_block_transposition import kbt_pkg::*; ();

  localparam int KEY_MAX      = KEY_BYTES;
  localparam int DRAIN_CYCLES = 2 * KEY_MAX + 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_MAX    = 50;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } msg_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } res_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kbt_msg_if msg ();
  kbt_res_if res ();
  kbt_cfg_if cfg ();

  keyed_block_transposition #(.KEY_MAX(KEY_MAX)) DUT (
    .clk (clk),
    .rst (rst),
    .msg (msg),
    .res (res),
    .cfg (cfg)
  );

  always #2 clk = ~clk;

  // pending message words and the output words they must produce
  msg_word_t   msg_bytes_q[$];
  res_word_t   res_words_due[$];
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  bit          hold_go = 1'b0;
  logic        hold_on;

  // shadow copy of the block's registers and row
  logic [KEY_LEN_W-1:0]  key_len_r;
  logic [CFG_DATA_W-1:0] key_lo_r;
  logic [CFG_DATA_W-1:0] key_hi_r;
  logic                  dec_r;
  logic [BYTE_W-1:0]     row_q[KEY_MAX];
  int unsigned           row_cnt;
  logic [3:0]            col_order[KEY_MAX];

  // stimulus-side view of the current width and mode
  int unsigned cur_w = KEY_LEN_MIN;
  bit          cur_dec = 1'b0;

  function automatic int unsigned width_of(logic [KEY_LEN_W-1:0] v);
    if (v < KEY_LEN_MIN) return KEY_LEN_MIN;
    if (v > KEY_MAX) return KEY_MAX;
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] key_at(int unsigned i);
    if (i < KEY_HALF) return key_lo_r[8*i +: 8];
    if (i < KEY_BYTES) return key_hi_r[8*(i-KEY_HALF) +: 8];
    return '0;
  endfunction

  // stable insertion sort of column indices by key byte
  function automatic void sort_columns();
    int unsigned w;
    int unsigned j;
    logic [3:0]  cur;
    w = width_of(key_len_r);
    for (int i = 0; i < KEY_MAX; i++) col_order[i] = 4'(i);
    for (int i = 1; i < w; i++) begin
      cur = col_order[i];
      j = i;
      while (j > 0 && key_at(col_order[j-1]) > key_at(cur)) begin
        col_order[j] = col_order[j-1];
        j--;
      end
      col_order[j] = cur;
    end
  endfunction

  function automatic void reset_shadow();
    key_len_r = KEY_LEN_W'(KEY_LEN_MIN);
    key_lo_r  = '0;
    key_hi_r  = '0;
    dec_r     = 1'b0;
    row_cnt   = 0;
    sort_columns();
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_KEY_LENGTH: begin
        key_len_r = d[KEY_LEN_W-1:0];
        row_cnt = 0;
        sort_columns();
      end
      REG_KEY_LOW: begin
        key_lo_r = d;
        sort_columns();
      end
      REG_KEY_HIGH: begin
        key_hi_r = d;
        sort_columns();
      end
      REG_MODE: begin
        dec_r = d[0];
        row_cnt = 0;
      end
      default: ;
    endcase
  endfunction

  // add one message word to the row and queue the output words it releases
  function automatic void transpose_byte(msg_word_t m);
    int unsigned       w;
    int unsigned       keep;
    logic [BYTE_W-1:0] plain[KEY_MAX];
    w = width_of(key_len_r);
    if (row_cnt >= w) row_cnt = 0;
    row_q[row_cnt] = m.data;
    row_cnt++;
    if (!dec_r) begin
      if (row_cnt < w && !m.last) return;
      for (int c = row_cnt; c < w; c++) row_q[c] = PAD_BYTE;
      for (int c = 0; c < w; c++)
        res_words_due.push_back(res_word_t'{row_q[col_order[c]], m.last && c == w - 1, 1'b0});
      row_cnt = 0;
      return;
    end
    if (row_cnt < w) begin
      if (!m.last) return;
      // short final decrypt row: one status word, row dropped
      row_cnt = 0;
      res_words_due.push_back(res_word_t'{'0, 1'b1, 1'b1});
      return;
    end
    for (int c = 0; c < w; c++) plain[col_order[c]] = row_q[c];
    keep = w;
    if (m.last)
      while (keep > 0 && plain[keep-1] == PAD_BYTE) keep--;
    for (int c = 0; c < keep; c++)
      res_words_due.push_back(res_word_t'{plain[c], m.last && c == keep - 1, 1'b0});
    row_cnt = 0;
  endfunction

  task automatic report_bad(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("ERROR cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
  endtask

  // message driver and input-side prediction
  always @(posedge clk) begin
    msg_word_t nxt;
    if (rst) begin
      msg.valid <= 1'b0;
      msg.in_byte <= '0;
      msg.in_last <= 1'b0;
      reset_shadow();
    end else begin
      if (cfg.valid && cfg.ready) apply_reg(cfg.reg_index, cfg.wdata);
      if (msg.valid && msg.ready) begin
        transpose_byte(msg_word_t'{msg.in_byte, msg.in_last});
        n_taken++;
      end
      if (!msg.valid || msg.ready) begin
        if (msg_bytes_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = msg_bytes_q.pop_front();
          msg.valid <= 1'b1;
          msg.in_byte <= nxt.data;
          msg.in_last <= nxt.last;
        end else begin
          msg.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    res_word_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (res_words_due.size() == 0) begin
          report_bad("word with none due, out_byte", res.out_byte, 0);
        end else begin
          want = res_words_due.pop_front();
          if (res.out_byte !== want.data) report_bad("out_byte", res.out_byte, want.data);
          if (res.out_last !== want.last) report_bad("out_last", res.out_last, want.last);
          if (res.status !== want.err) report_bad("status", res.status, want.err);
        end
      end
      res.ready <= !hold_on && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic put_byte(logic [BYTE_W-1:0] d, logic l);
    msg_bytes_q.push_back(msg_word_t'{d, l});
    n_queued++;
  endtask

  // the message's last w bytes turn into pad with the given odds
  task automatic queue_msg(int unsigned len, bit close, int unsigned pad_pct, int unsigned w);
    logic [BYTE_W-1:0] d;
    for (int unsigned k = 0; k < len; k++) begin
      d = BYTE_W'($urandom);
      if (k + w >= len && $urandom_range(99) < pad_pct) d = PAD_BYTE;
      put_byte(d, close && k == len - 1);
    end
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata <= d;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // all words taken, all results back, then let a possible empty row finish
  task automatic settle();
    do @(posedge clk); while (n_taken != n_queued || res_words_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_key();
    logic [CFG_DATA_W-1:0] k;
    case ($urandom_range(5))
      0: k = '1;
      1: k = '0;
      2, 3: for (int b = 0; b < 8; b++) k[8*b +: 8] = 8'($urandom_range(3));
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  task automatic random_setup();
    logic [KEY_LEN_W-1:0] kl;
    logic                 md;
    if ($urandom_range(99) < 70) begin
      case ($urandom_range(9))
        0: kl = KEY_LEN_W'(KEY_LEN_MIN);
        1: kl = KEY_LEN_W'(KEY_MAX);
        2: kl = KEY_LEN_W'($urandom_range(1));
        3: kl = KEY_LEN_W'($urandom_range(31, KEY_MAX + 1));
        default: kl = KEY_LEN_W'($urandom_range(6, 2));
      endcase
      cfg_write(REG_KEY_LENGTH, CFG_DATA_W'(kl));
      cur_w = width_of(kl);
    end
    if ($urandom_range(99) < 70) cfg_write(REG_KEY_LOW, pick_key());
    if ($urandom_range(99) < 50) cfg_write(REG_KEY_HIGH, pick_key());
    if ($urandom_range(99) < 50) begin
      md = 1'($urandom);
      cfg_write(REG_MODE, CFG_DATA_W'(md));
      cur_dec = md;
    end
  endtask

  // decrypt traffic is mostly whole rows; the rest has broken lengths
  task automatic random_traffic(int unsigned budget);
    int unsigned sent;
    int unsigned len;
    int unsigned w;
    sent = 0;
    w = cur_w;
    while (sent < budget) begin
      if (cur_dec) begin
        if ($urandom_range(99) < 80)
          len = w * $urandom_range(1, (w == KEY_MAX) ? 1 : 3);
        else
          len = $urandom_range(1, 3 * w);
        queue_msg(len, 1'b1, 50, w);
      end else begin
        len = $urandom_range(1, (w == KEY_MAX) ? w : 3 * w);
        queue_msg(len, 1'b1, 10, w);
      end
      sent += len;
    end
    // sometimes leave a message open across the next register writes
    if ($urandom_range(99) < 30) queue_msg($urandom_range(1, w - 1), 1'b0, 0, w);
    settle();
  endtask

  initial begin
    msg.valid = 1'b0;
    msg.in_byte = '0;
    msg.in_last = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.reg_index = '0;
    cfg.wdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset key: one byte padded out to a two byte row
    put_byte(8'h00, 1'b1);
    settle();

    // oversized width clamps to the max; keys with ties and extremes
    cfg_write(REG_KEY_LENGTH, CFG_DATA_W'(31));
    cfg_write(REG_KEY_LOW, 64'h00FF_8001_FF00_7F80);
    cfg_write(REG_KEY_HIGH, 64'h0101_FFFF_0000_8001);
    cur_w = KEY_MAX;
    for (int k = 0; k < KEY_MAX; k++)
      put_byte((k == 0) ? 8'h00 : (k == 1) ? 8'hFF : BYTE_W'($urandom), k == KEY_MAX - 1);
    settle();

    // decrypt, width below the min clamps to two
    cfg_write(REG_MODE, CFG_DATA_W'(1));
    cfg_write(REG_KEY_LENGTH, CFG_DATA_W'(0));
    cur_w = KEY_LEN_MIN;
    cur_dec = 1'b1;
    put_byte(8'h5A, 1'b1);
    put_byte(PAD_BYTE, 1'b0);
    put_byte(PAD_BYTE, 1'b1);
    put_byte(PAD_BYTE, 1'b0);
    put_byte(8'h41, 1'b0);
    put_byte(PAD_BYTE, 1'b0);
    put_byte(8'h42, 1'b1);
    put_byte(8'h33, 1'b0);
    settle();
    // mode change drops the open row
    cfg_write(REG_MODE, CFG_DATA_W'(0));
    cur_dec = 1'b0;

    // fill the block while the receiver holds off
    cfg_write(REG_KEY_LENGTH, CFG_DATA_W'(4));
    cur_w = 4;
    hold_go = 1'b1;
    queue_msg(30, 1'b1, 10, cur_w);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 52; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 52; end
        default: begin snd_idle_pct = 36; rcv_stall_pct = 36; end
      endcase
      repeat (2) begin
        random_setup();
        random_traffic(14);
      end
    end

    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    settle();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/kbt_pkg.sv
sv/kbt_if.sv
sv/kbt_ctrl.sv
sv/kbt_dp.sv
sv/keyed_block_transposition.sv
sv/kbt_checker.sv
test/tb_keyed_block_transposition.sv
